@@ src/narp_pkg.sv @@
// ----------------------------------------------------------------------------
// narp_pkg
// Shared constants, codes and types of the note arpeggiator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package narp_pkg;

   localparam int MAX_NOTES   = 8;
   localparam int SEQ_STEPS   = 8;
   localparam int SLOT_IDX_W  = $clog2(MAX_NOTES);
   localparam int COUNT_W     = $clog2(MAX_NOTES + 1);
   localparam int SEQ_SEL_W   = 3;

   localparam int CMD_W       = 2;
   localparam int NOTE_IN_W   = 7;
   localparam int CLOCK_W     = 32;
   localparam int NOTE_W      = 8;
   localparam int VEL_W       = 7;
   localparam int STEP_W      = 8;
   localparam int OCT_W       = 3;
   localparam int MODE_W      = 3;
   localparam int INTERVAL_W  = 7;
   localparam int PHASE_W     = 7;
   localparam int SPAN_W      = 2;
   localparam int TRANSPOSE_W = 7;
   localparam int OFFSETS_W   = 64;
   localparam int GATES_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int REM_W       = INTERVAL_W;
   localparam int DIV_STEPS   = CLOCK_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [NOTE_W-1:0]     EMPTY_SLOT           = 8'hFF;
   localparam logic [NOTE_W-1:0]     SEMITONES_PER_OCTAVE = 8'd12;
   localparam logic [VEL_W-1:0]      VEL_ON               = 7'd127;
   localparam logic [VEL_W-1:0]      VEL_OFF              = 7'd0;
   localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RESET  = 7'd24;
   localparam logic [GATES_W-1:0]    SEQ_GATES_RESET      = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_PRESS   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2,
      CMD_CLEAR   = 2'd3
   } narp_cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF   = 3'd0,
      MODE_UP    = 3'd1,
      MODE_DOWN  = 3'd2,
      MODE_CYCLE = 3'd3,
      MODE_SEQ   = 3'd4,
      MODE_CHORD = 3'd5
   } narp_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ARP_MODE      = 3'd0,
      REG_KEY_TRACK     = 3'd1,
      REG_STEP_INTERVAL = 3'd2,
      REG_STEP_PHASE    = 3'd3,
      REG_OCTAVE_SPAN   = 3'd4,
      REG_TRANSPOSE     = 3'd5,
      REG_SEQ_OFFSETS   = 3'd6,
      REG_SEQ_GATES     = 3'd7
   } narp_reg_type;

   typedef struct packed {
      logic              insert;
      logic              remove;
      logic              shift;
      logic [NOTE_W-1:0] key;
   } narp_cell_ctrl_type;

endpackage

@@ src/narp_req_if.sv @@
// ----------------------------------------------------------------------------
// narp_req_if
// Input channel: command, note and master tick count with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface narp_req_if;
   import narp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [NOTE_IN_W-1:0] note;
   logic [CLOCK_W-1:0]   master_clock;

   modport source (output valid, cmd, note, master_clock, input ready);
   modport sink   (input valid, cmd, note, master_clock, output ready);
endinterface

@@ src/narp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// narp_rsp_if
// Result channel: note-on/note-off events with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface narp_rsp_if;
   import narp_pkg::*;

   logic              valid;
   logic              ready;
   logic              event_kind;
   logic [NOTE_W-1:0] note_out;
   logic [VEL_W-1:0]  velocity;
   logic              last;

   modport source (output valid, event_kind, note_out, velocity, last, input ready);
   modport sink   (input valid, event_kind, note_out, velocity, last, output ready);
endinterface

@@ src/narp_cell.sv @@
// ----------------------------------------------------------------------------
// narp_cell
// One slot of the sorted held-note list; trades notes with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module narp_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  narp_pkg::narp_cell_ctrl_type ctrl,
   input  logic [narp_pkg::NOTE_W-1:0]  left_note,
   input  logic                         left_gt,
   input  logic                         hit_in,
   input  logic [narp_pkg::NOTE_W-1:0]  right_note,
   output logic [narp_pkg::NOTE_W-1:0]  note,
   output logic                         gt_out,
   output logic                         hit_out
);
   import narp_pkg::*;

   logic [NOTE_W-1:0] note_ff;
   logic [NOTE_W-1:0] note_in;

   assign gt_out  = note_ff > ctrl.key;
   assign hit_out = hit_in | (note_ff == ctrl.key);
   assign note    = note_ff;

   always_comb begin
      note_in = note_ff;
      if (ctrl.insert && gt_out) begin
         note_in = left_gt ? left_note : ctrl.key;
      end else if (ctrl.remove && hit_out) begin
         note_in = right_note;
      end else if (ctrl.shift) begin
         note_in = right_note;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff <= EMPTY_SLOT;
      end else begin
         note_ff <= note_in;
      end
   end
endmodule

@@ src/narp_rem_unit.sv @@
// ----------------------------------------------------------------------------
// narp_rem_unit
// Remainder of the 32-bit tick count by the step interval, two bits a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module narp_rem_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [narp_pkg::CLOCK_W-1:0]    dividend,
   input  logic [narp_pkg::INTERVAL_W-1:0] divisor,
   output logic [narp_pkg::REM_W-1:0]      rem,
   output logic                            done
);
   import narp_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [CLOCK_W-1:0]   quo_ff;
   logic [REM_W-1:0]     rem_ff;

   logic [REM_W:0]       div_ext;
   logic [REM_W:0]       part1;
   logic [REM_W:0]       red1;
   logic [REM_W:0]       part2;
   logic [REM_W:0]       red2;

   assign div_ext = {1'b0, divisor};
   assign part1   = {rem_ff, quo_ff[CLOCK_W-1]};
   assign red1    = (part1 >= div_ext) ? part1 - div_ext : part1;
   assign part2   = {red1[REM_W-1:0], quo_ff[CLOCK_W-2]};
   assign red2    = (part2 >= div_ext) ? part2 - div_ext : part2;

   assign rem  = rem_ff;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[CLOCK_W-3:0], 2'b00};
         rem_ff <= red2[REM_W-1:0];
      end
   end
endmodule

@@ src/note_arpeggiator_core.sv @@
// ----------------------------------------------------------------------------
// note_arpeggiator_core
// Arpeggiator over a sorted list of up to eight held notes. The core works on
// one item at a time and takes the next one only after the last result of the
// current item sits in the output register. A clear puts out one note-off per
// held note. A tick does nothing while the arpeggiator is idle. Otherwise,
// with a nonzero step interval it waits on the remainder unit that retires
// two bits of the 32-bit tick count per cycle; with a zero interval it checks
// the tick count against the phase directly. A stalled output holds back the
// item whose result waits on it. The held notes live in a row of cells that
// shift among neighbors for insert, remove and clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module note_arpeggiator_core (
   input  logic                             clock,
   input  logic                             reset,
   narp_req_if.sink                         req_bus,
   narp_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [narp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [narp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import narp_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0_0000_0000_0001,
      ST_PRESS  = 13'b0_0000_0000_0010,
      ST_BASE   = 13'b0_0000_0000_0100,
      ST_REL    = 13'b0_0000_0000_1000,
      ST_RELFIX = 13'b0_0000_0001_0000,
      ST_RELOUT = 13'b0_0000_0010_0000,
      ST_TICK   = 13'b0_0000_0100_0000,
      ST_DIV    = 13'b0_0000_1000_0000,
      ST_TRIG   = 13'b0_0001_0000_0000,
      ST_PLAY   = 13'b0_0010_0000_0000,
      ST_OFF    = 13'b0_0100_0000_0000,
      ST_ON     = 13'b0_1000_0000_0000,
      ST_CLR    = 13'b1_0000_0000_0000
   } narp_state_type;

   // configuration
   logic [MODE_W-1:0]      arp_mode_ff, arp_mode_in;
   logic                   key_track_ff, key_track_in;
   logic [INTERVAL_W-1:0]  step_interval_ff, step_interval_in;
   logic [PHASE_W-1:0]     step_phase_ff, step_phase_in;
   logic [SPAN_W-1:0]      octave_span_ff, octave_span_in;
   logic [TRANSPOSE_W-1:0] transpose_ff, transpose_in;
   logic [OFFSETS_W-1:0]   seq_offsets_ff, seq_offsets_in;
   logic [GATES_W-1:0]     seq_gates_ff, seq_gates_in;

   // control state
   narp_state_type         state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [OCT_W-1:0]       octave_ff, octave_in;
   logic                   down_ff, down_in;
   logic [NOTE_W-1:0]      playing_ff, playing_in;
   logic [NOTE_W-1:0]      base_ff, base_in;
   logic                   prev_trig_ff, prev_trig_in;
   logic                   trig_ff, trig_in;
   logic                   gate_ff, gate_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   logic [NOTE_IN_W-1:0]   note_item_ff, note_item_in;
   logic [CLOCK_W-1:0]     clock_item_ff, clock_item_in;
   logic [NOTE_W-1:0]      next_note_ff, next_note_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [NOTE_W-1:0]      rsp_note_ff, rsp_note_in;
   logic                   rsp_last_ff, rsp_last_in;

   // cell row
   narp_cell_ctrl_type     cell_ctrl;
   logic [NOTE_W-1:0]      cell_note [MAX_NOTES];
   logic [MAX_NOTES-1:0]   cell_gt;
   logic [MAX_NOTES-1:0]   cell_hit;

   // remainder unit
   logic                   div_start;
   logic [REM_W-1:0]       div_rem;
   logic                   div_done;

   // datapath helpers
   logic                   can_load;
   logic [STEP_W:0]        count_ext;
   logic                   step_lt_top;
   logic [STEP_W-1:0]      top_step;
   logic [STEP_W-1:0]      cyc_step;
   logic                   cyc_lt_top;
   logic [SEQ_SEL_W-1:0]   seq_sel;
   logic [NOTE_W-1:0]      seq_note;
   logic [NOTE_W-1:0]      slot_note;
   logic [OCT_W-1:0]       oct_clamp;
   logic [NOTE_W-1:0]      oct_semis;
   logic [NOTE_W-1:0]      clamp_semis;
   logic [NOTE_W-1:0]      trans_ext;
   logic [NOTE_W-1:0]      chord_note;

   for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
      logic [NOTE_W-1:0] left_note;
      logic [NOTE_W-1:0] right_note;
      logic              left_gt;
      logic              hit_in;

      if (i == 0) begin : g_head
         assign left_note = EMPTY_SLOT;
         assign left_gt   = 1'b0;
         assign hit_in    = 1'b0;
      end else begin : g_body
         assign left_note = cell_note[i-1];
         assign left_gt   = cell_gt[i-1];
         assign hit_in    = cell_hit[i-1];
      end

      if (i == MAX_NOTES - 1) begin : g_tail
         assign right_note = EMPTY_SLOT;
      end else begin : g_link
         assign right_note = cell_note[i+1];
      end

      narp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .left_note  (left_note),
         .left_gt    (left_gt),
         .hit_in     (hit_in),
         .right_note (right_note),
         .note       (cell_note[i]),
         .gt_out     (cell_gt[i]),
         .hit_out    (cell_hit[i])
      );
   end

   narp_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_item_ff),
      .divisor  (step_interval_ff),
      .rem      (div_rem),
      .done     (div_done)
   );

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.event_kind = rsp_kind_ff;
   assign rsp_bus.note_out   = rsp_note_ff;
   assign rsp_bus.velocity   = rsp_kind_ff ? VEL_ON : VEL_OFF;
   assign rsp_bus.last       = rsp_last_ff;

   assign can_load = !rsp_valid_ff || rsp_bus.ready;

   // step arithmetic against the top of the list (count - 1, may be -1)
   assign count_ext   = (STEP_W + 1)'(count_ff);
   assign step_lt_top = ({1'b0, step_ff} + 1'b1) < count_ext;
   assign top_step    = STEP_W'(count_ff) - 1'b1;
   assign cyc_step    = (!down_ff && step_lt_top) ? step_ff + 1'b1 :
                        (down_ff && step_ff != '0) ? step_ff - 1'b1 : step_ff;
   assign cyc_lt_top  = ({1'b0, cyc_step} + 1'b1) < count_ext;

   assign seq_sel     = step_ff[SEQ_SEL_W-1:0];
   assign seq_note    = base_ff + seq_offsets_ff[seq_sel * NOTE_W +: NOTE_W];
   assign slot_note   = (step_ff < STEP_W'(MAX_NOTES)) ?
                        cell_note[step_ff[SLOT_IDX_W-1:0]] : EMPTY_SLOT;
   assign oct_clamp   = (octave_ff > OCT_W'(octave_span_ff)) ? '0 : octave_ff;
   assign oct_semis   = NOTE_W'(octave_ff) * SEMITONES_PER_OCTAVE;
   assign clamp_semis = NOTE_W'(oct_clamp) * SEMITONES_PER_OCTAVE;
   assign trans_ext   = {transpose_ff[TRANSPOSE_W-1], transpose_ff};
   assign chord_note  = slot_note + clamp_semis + trans_ext;

   always_comb begin
      arp_mode_in      = arp_mode_ff;
      key_track_in     = key_track_ff;
      step_interval_in = step_interval_ff;
      step_phase_in    = step_phase_ff;
      octave_span_in   = octave_span_ff;
      transpose_in     = transpose_ff;
      seq_offsets_in   = seq_offsets_ff;
      seq_gates_in     = seq_gates_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_ARP_MODE:      arp_mode_in      = csr_wdata[MODE_W-1:0];
            REG_KEY_TRACK:     key_track_in     = csr_wdata[0];
            REG_STEP_INTERVAL: step_interval_in = csr_wdata[INTERVAL_W-1:0];
            REG_STEP_PHASE:    step_phase_in    = csr_wdata[PHASE_W-1:0];
            REG_OCTAVE_SPAN:   octave_span_in   = csr_wdata[SPAN_W-1:0];
            REG_TRANSPOSE:     transpose_in     = csr_wdata[TRANSPOSE_W-1:0];
            REG_SEQ_OFFSETS:   seq_offsets_in   = csr_wdata[OFFSETS_W-1:0];
            REG_SEQ_GATES:     seq_gates_in     = csr_wdata[GATES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      octave_in     = octave_ff;
      down_in       = down_ff;
      playing_in    = playing_ff;
      base_in       = base_ff;
      prev_trig_in  = prev_trig_ff;
      trig_in       = trig_ff;
      gate_in       = gate_ff;
      note_item_in  = note_item_ff;
      clock_item_in = clock_item_ff;
      next_note_in  = next_note_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctrl     = '0;
      cell_ctrl.key = NOTE_W'(note_item_ff);
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               note_item_in  = req_bus.note;
               clock_item_in = req_bus.master_clock;
               case (req_bus.cmd)
                  CMD_PRESS:   state_in = ST_PRESS;
                  CMD_RELEASE: state_in = ST_REL;
                  CMD_TICK:    state_in = ST_TICK;
                  default:     state_in = ST_CLR;
               endcase
            end
         end

         ST_PRESS: begin
            if (count_ff < COUNT_W'(MAX_NOTES)) begin
               cell_ctrl.insert = 1'b1;
               count_in         = count_ff + 1'b1;
               state_in         = ST_BASE;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_BASE: begin
            base_in  = cell_note[0];
            state_in = ST_IDLE;
         end

         ST_REL: begin
            cell_ctrl.remove = 1'b1;
            if (cell_hit[MAX_NOTES-1]) begin
               count_in = count_ff - 1'b1;
            end
            state_in = ST_RELFIX;
         end

         ST_RELFIX: begin
            if (!key_track_ff) begin
               if (count_ff != '0) begin
                  if (step_ff >= STEP_W'(count_ff)) begin
                     step_in = top_step;
                  end
               end else if (arp_mode_ff == MODE_SEQ) begin
                  step_in = STEP_W'(SEQ_STEPS - 1);
               end else begin
                  step_in = '0;
               end
            end
            if (arp_mode_ff != MODE_OFF && !key_track_ff) begin
               state_in = ST_RELOUT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_RELOUT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_note_in  = NOTE_W'(note_item_ff) + oct_semis;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_TICK: begin
            if (arp_mode_ff == MODE_OFF || (count_ff == '0 && !key_track_ff)) begin
               state_in = ST_IDLE;
            end else if (step_interval_ff == '0) begin
               trig_in  = (clock_item_ff == CLOCK_W'(step_phase_ff));
               state_in = ST_TRIG;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               trig_in  = (div_rem == step_phase_ff);
               state_in = ST_TRIG;
            end
         end

         ST_TRIG: begin
            prev_trig_in = trig_ff;
            if (trig_ff && !prev_trig_ff) begin
               case (arp_mode_ff)
                  MODE_UP: begin
                     if (step_lt_top) begin
                        step_in = step_ff + 1'b1;
                     end else begin
                        step_in   = '0;
                        octave_in = octave_ff + 1'b1;
                     end
                  end
                  MODE_DOWN: begin
                     if (step_ff != '0) begin
                        step_in = step_ff - 1'b1;
                     end else begin
                        step_in   = top_step;
                        octave_in = octave_ff + 1'b1;
                     end
                  end
                  MODE_CYCLE: begin
                     step_in = cyc_step;
                     if (cyc_step == '0) begin
                        down_in = 1'b0;
                     end else if (!cyc_lt_top) begin
                        down_in = 1'b1;
                     end
                  end
                  MODE_SEQ: begin
                     if (step_ff < STEP_W'(SEQ_STEPS - 1)) begin
                        step_in = step_ff + 1'b1;
                     end else begin
                        step_in = '0;
                     end
                  end
                  default: ;
               endcase
               state_in = ST_PLAY;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PLAY: begin
            if (arp_mode_ff == MODE_SEQ) begin
               next_note_in = seq_note;
               gate_in      = seq_gates_ff[seq_sel];
            end else begin
               octave_in    = oct_clamp;
               next_note_in = chord_note;
               gate_in      = 1'b1;
            end
            state_in = ST_OFF;
         end

         ST_OFF: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_note_in  = playing_ff;
               rsp_last_in  = !gate_ff;
               playing_in   = next_note_ff;
               state_in     = gate_ff ? ST_ON : ST_IDLE;
            end
         end

         ST_ON: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_note_in  = playing_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_CLR: begin
            if (count_ff == '0) begin
               step_in    = (arp_mode_ff == MODE_SEQ) ? STEP_W'(SEQ_STEPS - 1) : '0;
               playing_in = '0;
               state_in   = ST_IDLE;
            end else if (can_load) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = 1'b0;
               rsp_note_in     = cell_note[0] + oct_semis;
               rsp_last_in     = (count_ff == COUNT_W'(1));
               cell_ctrl.shift = 1'b1;
               count_in        = count_ff - 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arp_mode_ff      <= MODE_OFF;
         key_track_ff     <= 1'b0;
         step_interval_ff <= STEP_INTERVAL_RESET;
         step_phase_ff    <= '0;
         octave_span_ff   <= '0;
         transpose_ff     <= '0;
         seq_offsets_ff   <= '0;
         seq_gates_ff     <= SEQ_GATES_RESET;
         state_ff         <= ST_IDLE;
         count_ff         <= '0;
         step_ff          <= '0;
         octave_ff        <= '0;
         down_ff          <= 1'b0;
         playing_ff       <= '0;
         base_ff          <= '0;
         prev_trig_ff     <= 1'b0;
         trig_ff          <= 1'b0;
         gate_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         arp_mode_ff      <= arp_mode_in;
         key_track_ff     <= key_track_in;
         step_interval_ff <= step_interval_in;
         step_phase_ff    <= step_phase_in;
         octave_span_ff   <= octave_span_in;
         transpose_ff     <= transpose_in;
         seq_offsets_ff   <= seq_offsets_in;
         seq_gates_ff     <= seq_gates_in;
         state_ff         <= state_in;
         count_ff         <= count_in;
         step_ff          <= step_in;
         octave_ff        <= octave_in;
         down_ff          <= down_in;
         playing_ff       <= playing_in;
         base_ff          <= base_in;
         prev_trig_ff     <= prev_trig_in;
         trig_ff          <= trig_in;
         gate_ff          <= gate_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      note_item_ff  <= note_item_in;
      clock_item_ff <= clock_item_in;
      next_note_ff  <= next_note_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_last_ff   <= rsp_last_in;
   end
endmodule

@@ src/narp_checker.sv @@
// ----------------------------------------------------------------------------
// narp_port_checks
// Port-level checks of the note arpeggiator core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module narp_port_checks (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_event_kind,
   input logic [narp_pkg::NOTE_W-1:0] rsp_note_out,
   input logic [narp_pkg::VEL_W-1:0]  rsp_velocity,
   input logic                        rsp_last
);
   import narp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note_out) &&
         $stable(rsp_event_kind) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind ? rsp_velocity == VEL_ON : rsp_velocity == VEL_OFF))
      else $error("velocity does not match event kind");

   a_on_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind |-> rsp_last)
      else $error("note-on beat not marked last");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous item in work");

   a_busy_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready before last result of item");
endmodule

bind note_arpeggiator_core narp_port_checks u_narp_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_event_kind (rsp_bus.event_kind),
   .rsp_note_out   (rsp_bus.note_out),
   .rsp_velocity   (rsp_bus.velocity),
   .rsp_last       (rsp_bus.last)
);
